// ----- hdl/fem_pkg.sv -----
// Shared types, constants and the extension table of the file extension matcher.
// No dependencies; the tracker, the matcher and the top level import this package.
package fem_pkg;

	localparam int MAX_EXT_CHARS_DEF     = 8;
	localparam int EXT_TABLE_ENTRIES_DEF = 25;
	localparam int TABLE_SLOTS           = 32;
	localparam int ENTRY_BYTES           = 8;
	localparam int TABLE_IDX_W           = $clog2(TABLE_SLOTS);
	localparam int ENTRY_LEN_W           = $clog2(ENTRY_BYTES + 1);

	localparam logic [7:0] CHAR_DOT     = 8'h2e;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	// Byte 0 of an entry sits in text[7:0]; bytes past len are zero.
	typedef struct packed {
		logic [ENTRY_LEN_W-1:0]   len;
		logic [ENTRY_BYTES*8-1:0] text;
	} ext_entry_t;

	// Per-item control from the input stage to the extension tracker.
	typedef struct packed {
		logic step;
		logic last;
	} track_ctl_t;

	// Text literals are written with the last character first, so that the
	// first character lands in the low byte.
	function automatic ext_entry_t fem_entry(input logic [TABLE_IDX_W-1:0] idx);
		ext_entry_t e;
		e = '0;
		unique case (idx)
			5'd0:  e = '{len: 4'd3, text: {40'h0, "slx"}};
			5'd1:  e = '{len: 4'd4, text: {32'h0, "xslx"}};
			5'd2:  e = '{len: 4'd3, text: {40'h0, "cod"}};
			5'd3:  e = '{len: 4'd4, text: {32'h0, "xcod"}};
			5'd4:  e = '{len: 4'd3, text: {40'h0, "tpp"}};
			5'd5:  e = '{len: 4'd4, text: {32'h0, "xtpp"}};
			5'd6:  e = '{len: 4'd3, text: {40'h0, "fdp"}};
			5'd7:  e = '{len: 4'd3, text: {40'h0, "gpj"}};
			5'd8:  e = '{len: 4'd4, text: {32'h0, "gepj"}};
			5'd9:  e = '{len: 4'd3, text: {40'h0, "piz"}};
			5'd10: e = '{len: 4'd3, text: {40'h0, "4pm"}};
			5'd11: e = '{len: 4'd3, text: {40'h0, "txt"}};
			5'd12: e = '{len: 4'd3, text: {40'h0, "dsa"}};
			5'd13: e = '{len: 4'd4, text: {32'h0, "malx"}};
			5'd14: e = '{len: 4'd3, text: {40'h0, "mth"}};
			5'd15: e = '{len: 4'd4, text: {32'h0, "lmth"}};
			5'd16: e = '{len: 4'd3, text: {40'h0, "thm"}};
			5'd17: e = '{len: 4'd3, text: {40'h0, "lme"}};
			5'd18: e = '{len: 4'd3, text: {40'h0, "gsm"}};
			5'd19: e = '{len: 4'd3, text: {40'h0, "pwh"}};
			5'd20: e = '{len: 4'd3, text: {40'h0, "lug"}};
			5'd21: e = '{len: 4'd3, text: {40'h0, "ftr"}};
			5'd22: e = '{len: 4'd8, text: "elgnisym"};
			5'd23: e = '{len: 4'd3, text: {40'h0, "gnp"}};
			5'd24: e = '{len: 4'd3, text: {40'h0, "fig"}};
			default: e = '0;
		endcase
		return e;
	endfunction

endpackage

// ----- hdl/fem_in_if.sv -----
// Character request channel of the file extension matcher.
// Depends on nothing; payload widths are fixed by the character format.
interface fem_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] name_char;
	logic       last_char;

	modport source (output valid, name_char, last_char, input ready);
	modport sink   (input valid, name_char, last_char, output ready);
endinterface

// ----- hdl/fem_out_if.sv -----
// Result channel of the file extension matcher.
// Depends on nothing; one request per file name.
interface fem_out_if;
	logic valid;
	logic ready;
	logic dot_found;
	logic is_interested;

	modport source (output valid, dot_found, is_interested, input ready);
	modport sink   (input valid, dot_found, is_interested, output ready);
endinterface

// ----- hdl/fem_ext_track.sv -----
// Extension tracker: holds the folded characters after the latest dot.
// Depends on fem_pkg.
module fem_ext_track #(
	parameter int MAX_EXT_CHARS = fem_pkg::MAX_EXT_CHARS_DEF,
	parameter int CNT_W         = $clog2(MAX_EXT_CHARS + 2)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fem_pkg::track_ctl_t        ctl,
	input  logic [7:0]                 ch,
	output logic [MAX_EXT_CHARS*8-1:0] nxt_chars,
	output logic [CNT_W-1:0]           nxt_count,
	output logic                       nxt_dot
);
	import fem_pkg::*;

	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_EXT_CHARS);
	localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(MAX_EXT_CHARS + 1);

	logic [MAX_EXT_CHARS*8-1:0] ext_chars_q;
	logic [CNT_W-1:0]           ext_count_q;
	logic                       seen_dot_q;
	logic [7:0]                 folded;

	// Fold ASCII upper case only.
	assign folded = (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) ? ch + CASE_OFFSET : ch;

	always_comb begin
		nxt_chars = ext_chars_q;
		nxt_count = ext_count_q;
		nxt_dot   = seen_dot_q;
		if (ch == CHAR_DOT) begin
			nxt_chars = '0;
			nxt_count = '0;
			nxt_dot   = 1'b1;
		end else if (ext_count_q < CNT_MAX) begin
			for (int k = 0; k < MAX_EXT_CHARS; k++) begin
				if (ext_count_q == CNT_W'(k)) begin
					nxt_chars[k*8 +: 8] = folded;
				end
			end
			nxt_count = ext_count_q + CNT_W'(1);
		end else begin
			// Too long to match: saturate, drop the character.
			nxt_count = CNT_OVER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_chars_q <= '0;
			ext_count_q <= '0;
			seen_dot_q  <= 1'b0;
		end else if (ctl.step) begin
			if (ctl.last) begin
				ext_chars_q <= '0;
				ext_count_q <= '0;
				seen_dot_q  <= 1'b0;
			end else begin
				ext_chars_q <= nxt_chars;
				ext_count_q <= nxt_count;
				seen_dot_q  <= nxt_dot;
			end
		end
	end
endmodule

// ----- hdl/fem_ext_match.sv -----
// Table matcher: compares a folded extension with every table entry at once.
// Depends on fem_pkg (entry table).
module fem_ext_match #(
	parameter int MAX_EXT_CHARS     = fem_pkg::MAX_EXT_CHARS_DEF,
	parameter int EXT_TABLE_ENTRIES = fem_pkg::EXT_TABLE_ENTRIES_DEF,
	parameter int CNT_W             = $clog2(MAX_EXT_CHARS + 2)
) (
	input  logic [MAX_EXT_CHARS*8-1:0] chars,
	input  logic [CNT_W-1:0]           count,
	output logic                       hit
);
	import fem_pkg::*;

	ext_entry_t e;

	// Bytes past the count are always zero, so the low entry bytes and the
	// length settle the match.
	always_comb begin
		hit = 1'b0;
		e   = '0;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			e = fem_entry(TABLE_IDX_W'(i));
			if (i < EXT_TABLE_ENTRIES && count != '0
					&& count == CNT_W'(e.len)
					&& chars[ENTRY_BYTES*8-1:0] == e.text) begin
				hit = 1'b1;
			end
		end
	end
endmodule

// ----- hdl/file_extension_matcher_core.sv -----
// Top level of the file extension matcher: input stage, tracker, matcher, result register.
// Depends on fem_pkg, fem_in_if, fem_out_if, fem_ext_track, fem_ext_match.
//
//  channel | modport          | payload                    | requests
//  --------+------------------+----------------------------+----------------------------
//  chars   | fem_in_if.sink   | name_char[7:0], last_char  | one per character of a name
//  result  | fem_out_if.source| dot_found, is_interested   | one per name, on last_char
//
// Flow: one character a cycle sustained while no last character waits behind a
// held result; a request passes the input stage register, then the tracker update
// and table compare, and a last character's result is loaded into the result register as it leaves the stage.
// Reset: arst_n clears the extension state and both valid flags at once.
// Stalls: a held result blocks only a last character waiting behind it;
// other characters keep flowing, and chars.ready drops only when the result
// register and the input stage both hold a finished name.
module file_extension_matcher_core #(
	parameter int MAX_EXT_CHARS     = fem_pkg::MAX_EXT_CHARS_DEF,
	parameter int EXT_TABLE_ENTRIES = fem_pkg::EXT_TABLE_ENTRIES_DEF
) (
	input logic       clk,
	input logic       arst_n,
	fem_in_if.sink    chars,
	fem_out_if.source result
);
	import fem_pkg::*;

	localparam int CNT_W = $clog2(MAX_EXT_CHARS + 2);

	// Input stage.
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// Result register.
	logic       out_valid_q;
	logic       dot_found_q;
	logic       is_interested_q;

	logic                       out_free;
	logic                       go_s1;
	track_ctl_t                 ctl;
	logic [MAX_EXT_CHARS*8-1:0] nxt_chars;
	logic [CNT_W-1:0]           nxt_count;
	logic                       nxt_dot;
	logic                       hit;

	// A non-last character never needs the result register, so it always
	// advances; a last character waits until the result slot frees up.
	assign out_free    = !out_valid_q || result.ready;
	assign go_s1       = valid_s1 && (!last_s1 || out_free);
	assign chars.ready = !valid_s1 || go_s1;

	assign ctl.step = go_s1;
	assign ctl.last = last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	// Hold the payload while the stage stalls.
	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.name_char;
			last_s1 <= chars.last_char;
		end
	end

	fem_ext_track #(
		.MAX_EXT_CHARS (MAX_EXT_CHARS),
		.CNT_W         (CNT_W)
	) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.ch        (char_s1),
		.nxt_chars (nxt_chars),
		.nxt_count (nxt_count),
		.nxt_dot   (nxt_dot)
	);

	fem_ext_match #(
		.MAX_EXT_CHARS     (MAX_EXT_CHARS),
		.EXT_TABLE_ENTRIES (EXT_TABLE_ENTRIES),
		.CNT_W             (CNT_W)
	) u_match (
		.chars (nxt_chars),
		.count (nxt_count),
		.hit   (hit)
	);

	// Load a result on the last character; drop it once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			dot_found_q     <= nxt_dot;
			is_interested_q <= nxt_dot && hit;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.dot_found     = dot_found_q;
	assign result.is_interested = is_interested_q;
endmodule

// ----- hdl/fem_checker.sv -----
// Port-level checks of the file extension matcher, bound to the top level.
// Depends on file_extension_matcher_core (bind target) only.
module fem_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_last,
	input logic out_valid,
	input logic out_ready,
	input logic out_dot,
	input logic out_hit
);
	logic       in_fire;
	logic       out_fire;
	logic [1:0] pending_q;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	// Names accepted whose result is not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 2'((in_fire && in_last) ? 1 : 0) - 2'(out_fire ? 1 : 0);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_dot) && $stable(out_hit))
		else $error("result changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire |-> pending_q != 2'd0)
		else $error("result without a finished name");

	a_hit_needs_dot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !out_hit || out_dot)
		else $error("match reported without a dot");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 2'd0 |-> in_ready)
		else $error("input stalled with no name pending");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 2'd2 && !out_ready |-> !in_ready)
		else $error("input accepted with both stages full");
endmodule

bind file_extension_matcher_core fem_checker u_fem_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (chars.valid),
	.in_ready  (chars.ready),
	.in_last   (chars.last_char),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_dot   (result.dot_found),
	.out_hit   (result.is_interested)
);
